FILE: design/srsw_pkg.sv
// shared constants and types for the selective-repeat sender window
package srsw_pkg;

    localparam int CFG_W      = 6;
    localparam int SLOT_MAX_W = 8;

    localparam logic [CFG_W-1:0] WIN_RESET = 6'd8;

    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_ACK  = 2'd1;
    localparam logic [1:0] ACT_TMO  = 2'd2;

    typedef struct packed {
        logic                  we;
        logic                  wdata;
        logic                  clr;
        logic [SLOT_MAX_W-1:0] waddr;
        logic [SLOT_MAX_W-1:0] raddr;
    } t_mark_req;

endpackage

FILE: design/selective_repeat_sender_window.sv
// selective-repeat sender window tracker, top level with sequencer
// send, timeout or refused word: evaluated in S_EVAL, result loaded into the output register from S_DONE
// acknowledgement: mark set in S_EVAL, then S_RD and S_CHK slide the base past acked slots (one mark read per cycle)
// one word in flight, next taken the cycle after the result loads
// reset: 8-slot window clamped to MAX_WINDOW, empty ring, expected sequence 0, no clearing pass
module selective_repeat_sender_window import srsw_pkg::*; #(
    parameter int MAX_WINDOW = 32,
    parameter int SEQ_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_action,
    input  logic [SEQ_BITS-1:0]           i_ack_seq,
    input  logic                          i_ack_intact,
    input  logic [$clog2(MAX_WINDOW)-1:0] i_timeout_slot,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_accepted,
    output logic [$clog2(MAX_WINDOW)-1:0] o_slot,
    output logic [SEQ_BITS-1:0]           o_seq,
    output logic                          o_start_timer,
    output logic                          o_stop_timer,
    output logic [$clog2(MAX_WINDOW)-1:0] o_window_base,
    output logic [$clog2(MAX_WINDOW)-1:0] o_next_slot
);

    localparam int SW = $clog2(MAX_WINDOW);
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int XW = WW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    function automatic logic [WW-1:0] f_eff(input logic [CFG_W-1:0] v);
        if (v < CFG_W'(2)) begin
            return WW'(2);
        end else if (int'(v) > MAX_WINDOW) begin
            return WW'(MAX_WINDOW);
        end else begin
            return WW'(v);
        end
    endfunction

    function automatic logic [SW-1:0] f_inc(input logic [SW-1:0] x, input logic [WW-1:0] w);
        logic [XW-1:0] t;
        t = XW'(x) + XW'(1);
        return (t == XW'(w)) ? '0 : SW'(t);
    endfunction

    function automatic logic [SW-1:0] f_dist(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                             input logic [WW-1:0] w);
        if (a >= b) begin
            return a - b;
        end else begin
            return SW'(XW'(a) + XW'(w) - XW'(b));
        end
    endfunction

    logic [2:0]          r_state, n_state;
    logic [WW-1:0]       r_win;
    logic [SW-1:0]       r_base, n_base;
    logic [SW-1:0]       r_free, n_free;
    logic [SEQ_BITS-1:0] r_exp, n_exp;

    logic [1:0]          r_action;
    logic [SEQ_BITS-1:0] r_ack_seq;
    logic                r_ack_intact;
    logic [SW-1:0]       r_tslot;

    logic                r_res_acc, n_res_acc;
    logic [SW-1:0]       r_res_slot, n_res_slot;
    logic [SEQ_BITS-1:0] r_res_seq, n_res_seq;
    logic                r_res_start, n_res_start;
    logic                r_res_stop, n_res_stop;

    logic                r_out_valid;
    logic                out_load;
    logic                acked;
    t_mark_req           mark_req;

    srsw_mark_ram #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mark_req),
        .o_acked (acked)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        logic [SW-1:0]       cnt;
        logic [SW-1:0]       off;
        logic [SW-1:0]       ack_slot;
        logic [SEQ_BITS-1:0] seq_gap;
        logic [XW-1:0]       sum;

        n_state     = r_state;
        n_base      = r_base;
        n_free      = r_free;
        n_exp       = r_exp;
        n_res_acc   = r_res_acc;
        n_res_slot  = r_res_slot;
        n_res_seq   = r_res_seq;
        n_res_start = r_res_start;
        n_res_stop  = r_res_stop;

        mark_req       = '0;
        mark_req.clr   = i_cfg_we;
        mark_req.raddr = SLOT_MAX_W'(r_base);

        cnt      = f_dist(r_free, r_base, r_win);
        off      = f_dist(r_tslot, r_base, r_win);
        seq_gap  = r_ack_seq - r_exp;
        sum      = XW'(r_base) + XW'(seq_gap[SW-1:0]);
        ack_slot = (sum >= XW'(r_win)) ? SW'(sum - XW'(r_win)) : SW'(sum);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_res_acc   = 1'b0;
                n_res_slot  = '0;
                n_res_seq   = '0;
                n_res_start = 1'b0;
                n_res_stop  = 1'b0;
                n_state     = S_DONE;
                unique case (r_action)
                    ACT_SEND: begin
                        if (XW'(cnt) + XW'(1) != XW'(r_win)) begin
                            n_res_acc      = 1'b1;
                            n_res_slot     = r_free;
                            n_res_seq      = r_exp + SEQ_BITS'(cnt);
                            n_res_start    = 1'b1;
                            mark_req.we    = 1'b1;
                            mark_req.wdata = 1'b0;
                            mark_req.waddr = SLOT_MAX_W'(r_free);
                            n_free         = f_inc(r_free, r_win);
                        end
                    end
                    ACT_ACK: begin
                        if (r_ack_intact && (seq_gap < SEQ_BITS'(cnt))) begin
                            n_res_acc      = 1'b1;
                            n_res_slot     = ack_slot;
                            n_res_seq      = r_ack_seq;
                            n_res_stop     = 1'b1;
                            mark_req.we    = 1'b1;
                            mark_req.wdata = 1'b1;
                            mark_req.waddr = SLOT_MAX_W'(ack_slot);
                            n_state        = S_RD;
                        end
                    end
                    ACT_TMO: begin
                        if ((cnt != '0) && (XW'(r_tslot) < XW'(r_win)) && (off < cnt)) begin
                            n_res_acc   = 1'b1;
                            n_res_slot  = r_tslot;
                            n_res_seq   = r_exp + SEQ_BITS'(off);
                            n_res_start = 1'b1;
                            n_res_stop  = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if ((r_base != r_free) && acked) begin
                    mark_req.we    = 1'b1;
                    mark_req.wdata = 1'b0;
                    mark_req.waddr = SLOT_MAX_W'(r_base);
                    n_base         = f_inc(r_base, r_win);
                    n_exp          = r_exp + SEQ_BITS'(1);
                    mark_req.raddr = SLOT_MAX_W'(n_base);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= f_eff(WIN_RESET);
            r_base      <= '0;
            r_free      <= '0;
            r_exp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_exp   <= n_exp;
            if (i_cfg_we) begin
                r_win  <= f_eff(i_cfg_wdata);
                r_base <= '0;
                r_free <= '0;
            end else begin
                r_base <= n_base;
                r_free <= n_free;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action     <= i_action;
            r_ack_seq    <= i_ack_seq;
            r_ack_intact <= i_ack_intact;
            r_tslot      <= i_timeout_slot;
        end
        r_res_acc   <= n_res_acc;
        r_res_slot  <= n_res_slot;
        r_res_seq   <= n_res_seq;
        r_res_start <= n_res_start;
        r_res_stop  <= n_res_stop;
        if (out_load) begin
            o_accepted    <= r_res_acc;
            o_slot        <= r_res_slot;
            o_seq         <= r_res_seq;
            o_start_timer <= r_res_start;
            o_stop_timer  <= r_res_stop;
            o_window_base <= r_base;
            o_next_slot   <= r_free;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: design/srsw_mark_ram.sv
// acknowledge mark memory with per-entry valid bits and registered read
module srsw_mark_ram import srsw_pkg::*; #(
    parameter int MAX_WINDOW = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mark_req i_req,
    output logic      o_acked
);

    localparam int SW = $clog2(MAX_WINDOW);

    logic                  mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] r_vld;
    logic                  r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr[SW-1:0]] <= i_req.wdata;
        end
        r_rd_data <= mem[i_req.raddr[SW-1:0]];
        r_rd_vld  <= r_vld[i_req.raddr[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr[SW-1:0]] <= 1'b1;
        end
    end

    assign o_acked = r_rd_data & r_rd_vld;

endmodule
